### rtl/core/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants of the tile shelf allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsa_pkg;

  localparam int unsigned ORIGIN_W      = 31;
  localparam int unsigned RECT_W        = 16;
  localparam int unsigned SHIFT_W       = 32;
  localparam int unsigned TILE_W        = 11;
  localparam int unsigned STORE_W       = 30;
  localparam int unsigned STATE_W       = 31;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 30;
  localparam int unsigned SIZE_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [TILE_W-1:0]  TILE_WIDTH_RESET  = 11'd128;
  localparam logic [TILE_W-1:0]  TILE_HEIGHT_RESET = 11'd64;
  localparam logic [STORE_W-1:0] STORE_RESET       = '1;
  localparam logic [STATE_W-1:0] START_ROW_RESET   = 31'd20000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_WIDTH   = 3'd0,
    CFG_TILE_HEIGHT  = 3'd1,
    CFG_STORE_WIDTH  = 3'd2,
    CFG_STORE_HEIGHT = 3'd3,
    CFG_START_ROW    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TILE_W-1:0]  tile_w;
    logic [TILE_W-1:0]  tile_h;
    logic [STORE_W-1:0] store_w;
    logic [STORE_W-1:0] store_h;
  } tsa_cfg_t;

  typedef struct packed {
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [RECT_W-1:0]          size_w_m1;
    logic [RECT_W-1:0]          size_h_m1;
  } tsa_job_t;

endpackage

### rtl/core/tsa_if.sv
// ----------------------------------------------------------------------------
// tsa_req_if / tsa_rsp_if
// Valid/ready channels for allocation requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsa_req_if import tsa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ORIGIN_W-1:0] origin_x;
  logic signed [ORIGIN_W-1:0] origin_y;
  logic [RECT_W-1:0]          rect_width;
  logic [RECT_W-1:0]          rect_height;

  modport source (output valid, origin_x, origin_y, rect_width, rect_height, input ready);
  modport sink (input valid, origin_x, origin_y, rect_width, rect_height, output ready);
endinterface

interface tsa_rsp_if import tsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic                      too_wide;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;

  modport source (output valid, granted, too_wide, shift_x, shift_y, input ready);
  modport sink (input valid, granted, too_wide, shift_x, shift_y, output ready);
endinterface

### rtl/core/tsa_front.sv
// ----------------------------------------------------------------------------
// tsa_front
// Request intake: masks and normalizes sizes and registers one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_front import tsa_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsa_req_if.sink   req_i,
  output logic      job_valid_o,
  input  logic      job_ready_i,
  output tsa_job_t  job_o
);

  localparam int unsigned DW = (SIZE_BITS < RECT_W) ? SIZE_BITS : RECT_W;

  logic           vld_q;
  tsa_job_t       job_q, job_d;
  logic [DW-1:0]  w_m, h_m;

  assign w_m = req_i.rect_width[DW-1:0];
  assign h_m = req_i.rect_height[DW-1:0];

  // zero size acts as size one, so size minus one is zero
  always_comb begin
    job_d.origin_x  = req_i.origin_x;
    job_d.origin_y  = req_i.origin_y;
    job_d.size_w_m1 = (w_m == '0) ? '0 : RECT_W'(w_m) - RECT_W'(1);
    job_d.size_h_m1 = (h_m == '0) ? '0 : RECT_W'(h_m) - RECT_W'(1);
  end

  assign req_i.ready = !vld_q || job_ready_i;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req_i.ready) begin
      vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      job_q <= job_d;
    end
  end

endmodule

### rtl/core/tsa_fifo.sv
// ----------------------------------------------------------------------------
// tsa_fifo
// Short job queue between intake and allocation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_fifo import tsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tsa_job_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tsa_job_t out_data_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  tsa_job_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CW'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

### rtl/core/tsa_div.sv
// ----------------------------------------------------------------------------
// tsa_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_div import tsa_pkg::*; #(
  parameter int unsigned DW = SIZE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     dividend_i,
  input  logic [TILE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DW-1:0]     quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [TILE_W-1:0] rem_q, dvs_q;
  logic [DW-1:0]     quo_q;
  logic [TILE_W:0]   rem_sh, diff;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[TILE_W];

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TILE_W-1:0] : rem_sh[TILE_W-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

endmodule

### rtl/core/tsa_back.sv
// ----------------------------------------------------------------------------
// tsa_back
// Allocation engine: tile rounding, shelf decision, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_back import tsa_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tsa_cfg_t  cfg_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  tsa_job_t  job_i,
  tsa_rsp_if.source rsp_o
);

  localparam int unsigned DW     = (SIZE_BITS < RECT_W) ? SIZE_BITS : RECT_W;
  localparam int unsigned NEED_W = DW + 1 + TILE_W;
  localparam int unsigned SUM_W  = ((NEED_W > STATE_W) ? NEED_W : STATE_W) + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_W,
    ST_DIV_H,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e              state_q;
  tsa_job_t            job_q;
  logic [DW-1:0]       qw_q;
  logic [NEED_W-1:0]   need_w_q, need_h_q;
  logic [SUM_W-1:0]    sum_rh_q, sum_cw_q, row_sh_q;
  logic                wide_q;
  logic [STATE_W-1:0]  col_q, row_q, shelf_q;
  logic                out_vld_q, out_grant_q, out_wide_q;
  logic [SHIFT_W-1:0]  out_sx_q, out_sy_q;

  logic [TILE_W-1:0]   tw_eff, th_eff;
  logic                div_start, div_done;
  logic [DW-1:0]       div_dvd, div_quo;
  logic [TILE_W-1:0]   div_dvs;
  logic [DW:0]         qw2, qh2;
  logic [NEED_W-1:0]   mul_w, mul_h;
  logic [SUM_W-1:0]    new_rh, place_row;
  logic                fit_cur, fit_row, fit_new, ok, new_shelf, slot_free;
  logic [STATE_W-1:0]  place_col;
  logic [SHIFT_W-1:0]  ox_ext, oy_ext, shift_x, shift_y;

  assign tw_eff = (cfg_i.tile_w == '0) ? TILE_W'(1) : cfg_i.tile_w;
  assign th_eff = (cfg_i.tile_h == '0) ? TILE_W'(1) : cfg_i.tile_h;

  assign job_ready_o = (state_q == ST_IDLE);

  // width pass first, height pass on its done
  always_comb begin
    div_start = 1'b0;
    div_dvd   = job_i.size_w_m1[DW-1:0];
    div_dvs   = tw_eff;
    if (state_q == ST_IDLE) begin
      div_start = job_valid_i;
    end else if (state_q == ST_DIV_W) begin
      div_start = div_done;
      div_dvd   = job_q.size_h_m1[DW-1:0];
      div_dvs   = th_eff;
    end
  end

  tsa_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign qw2   = {1'b0, qw_q} + (DW+1)'(2);
  assign qh2   = {1'b0, div_quo} + (DW+1)'(2);
  assign mul_w = NEED_W'(qw2) * NEED_W'(tw_eff);
  assign mul_h = NEED_W'(qh2) * NEED_W'(th_eff);

  assign new_rh    = row_sh_q + SUM_W'(need_h_q);
  assign fit_cur   = !(sum_rh_q > SUM_W'(cfg_i.store_h));
  assign fit_row   = !(sum_cw_q > SUM_W'(cfg_i.store_w));
  assign fit_new   = !(new_rh > SUM_W'(cfg_i.store_h));
  assign ok        = fit_cur && (fit_row || fit_new);
  assign new_shelf = !fit_row;
  assign place_col = new_shelf ? '0 : col_q;
  assign place_row = new_shelf ? row_sh_q : SUM_W'(row_q);

  assign ox_ext  = {job_q.origin_x[ORIGIN_W-1], job_q.origin_x};
  assign oy_ext  = {job_q.origin_y[ORIGIN_W-1], job_q.origin_y};
  assign shift_x = SHIFT_W'(place_col) - ox_ext;
  assign shift_y = SHIFT_W'(place_row) - oy_ext;

  assign slot_free = !out_vld_q || rsp_o.ready;

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.granted  = out_grant_q;
  assign rsp_o.too_wide = out_wide_q;
  assign rsp_o.shift_x  = out_sx_q;
  assign rsp_o.shift_y  = out_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      qw_q        <= '0;
      need_w_q    <= '0;
      need_h_q    <= '0;
      sum_rh_q    <= '0;
      sum_cw_q    <= '0;
      row_sh_q    <= '0;
      wide_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= START_ROW_RESET;
      shelf_q     <= '0;
      out_vld_q   <= 1'b0;
      out_grant_q <= 1'b0;
      out_wide_q  <= 1'b0;
      out_sx_q    <= '0;
      out_sy_q    <= '0;
    end else begin
      if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            state_q <= ST_DIV_W;
          end
        end
        ST_DIV_W: begin
          if (div_done) begin
            qw_q    <= div_quo;
            state_q <= ST_DIV_H;
          end
        end
        ST_DIV_H: begin
          if (div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          need_w_q <= mul_w;
          need_h_q <= mul_h;
          state_q  <= ST_SUM;
        end
        ST_SUM: begin
          sum_rh_q <= SUM_W'(row_q) + SUM_W'(need_h_q);
          sum_cw_q <= SUM_W'(col_q) + SUM_W'(need_w_q);
          row_sh_q <= SUM_W'(row_q) + SUM_W'(shelf_q);
          wide_q   <= SUM_W'(need_w_q) > SUM_W'(cfg_i.store_w);
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_vld_q   <= 1'b1;
            out_grant_q <= ok;
            out_wide_q  <= wide_q;
            out_sx_q    <= ok ? shift_x : '0;
            out_sy_q    <= ok ? shift_y : '0;
            if (ok) begin
              row_q <= STATE_W'(place_row);
              if (new_shelf) begin
                col_q   <= STATE_W'(need_w_q);
                shelf_q <= STATE_W'(need_h_q);
              end else begin
                col_q <= STATE_W'(sum_cw_q);
                if (SUM_W'(shelf_q) < SUM_W'(need_h_q)) begin
                  shelf_q <= STATE_W'(need_h_q);
                end
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/tile_shelf_allocator_core.sv
// ----------------------------------------------------------------------------
// tile_shelf_allocator_core
// Shelf packing allocator for rectangles in a large tiled store.
//
//   channel  dir  handshake     beat
//   req_i    in   valid/ready   origin_x, origin_y, rect_width, rect_height
//   rsp_o    out  valid/ready   granted, too_wide, shift_x, shift_y
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// One request at a time in the engine; its time there is set by the shared
// bit-serial divider, run once for width and once for height, followed by
// the multiply, sum and decision states. Intake register plus a two-entry
// queue take new beats while the engine works; the result register holds
// a beat until taken, stalling the engine. Reset is asynchronous, active
// low; row starts at 20000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_shelf_allocator_core import tsa_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tsa_req_if.sink               req_i,
  tsa_rsp_if.source             rsp_o
);

  tsa_cfg_t cfg_q;
  logic     fr_valid, fr_ready, q_valid, q_ready;
  tsa_job_t fr_job, q_job;

  // start_row only reaches the row cursor through reset, which restores it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_w  <= TILE_WIDTH_RESET;
      cfg_q.tile_h  <= TILE_HEIGHT_RESET;
      cfg_q.store_w <= STORE_RESET;
      cfg_q.store_h <= STORE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TILE_WIDTH:   cfg_q.tile_w  <= cfg_data_i[TILE_W-1:0];
        CFG_TILE_HEIGHT:  cfg_q.tile_h  <= cfg_data_i[TILE_W-1:0];
        CFG_STORE_WIDTH:  cfg_q.store_w <= cfg_data_i[STORE_W-1:0];
        CFG_STORE_HEIGHT: cfg_q.store_h <= cfg_data_i[STORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tsa_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  tsa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_job),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_job)
  );

  tsa_back #(
    .SIZE_BITS(SIZE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .rsp_o       (rsp_o)
  );

endmodule
